// ----- hdl/sff_pkg.sv -----
// Shared types and constants for the threshold flood fill block.
// Used by the controller, the datapath and the top level; no dependencies.
package sff_pkg;

    localparam int DEF_IMAGE_WIDTH  = 64;
    localparam int DEF_IMAGE_HEIGHT = 64;
    localparam int DEF_STACK_DEPTH  = 1024;

    localparam int POS_W   = 6;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 13'd8191;
    localparam logic [CHAN_W-1:0]  TOLERANCE_RST = 8'd60;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FILL  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_BOOT_CLR,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_QRD,
        ST_FILL_CLR,
        ST_SEED_RD,
        ST_SEED_CK,
        ST_L_RD,
        ST_L_CK,
        ST_R_RD,
        ST_R_CK,
        ST_MARK,
        ST_PUSH,
        ST_POP,
        ST_POP_LD,
        ST_ROW,
        ST_S_RD,
        ST_S_CK,
        ST_FINISH
    } st_t;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_CLEAR,
        DP_LOAD,
        DP_QRD,
        DP_SEED_RD,
        DP_SEED_SET,
        DP_LRD,
        DP_LDEC,
        DP_RRD,
        DP_RINC,
        DP_MARK_INIT,
        DP_MARK,
        DP_PUSH,
        DP_POP,
        DP_POP_LD,
        DP_ROW_BELOW,
        DP_ROW_ABOVE,
        DP_SRD,
        DP_SSTEP,
        DP_SCLAIM,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        op_t  op;
        logic seed_in;
        logic clr_last;
        logic open;
        logic lo_zero;
        logic hi_last;
        logic mark_last;
        logic sp_zero;
        logic has_below;
        logic has_above;
        logic scan_end;
    } dp_stat_t;

endpackage

// ----- hdl/sff_ctrl.sv -----
// Controller state machine for the flood fill: sequences clear, span growth,
// marking, stack push/pop and row scans. Depends on sff_pkg.
module sff_ctrl
    import sff_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_op_t   cmd,
    output logic     busy
);

    st_t  state_reg, state_next;
    logic phase_reg, phase_next;   // 0: row below, 1: row above
    logic seed_reg, seed_next;     // current span grown from the seed

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT_CLR;
            phase_reg <= 1'b0;
            seed_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            seed_reg  <= seed_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        seed_next  = seed_reg;
        case (state_reg)
            ST_BOOT_CLR:
                if (stat.clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                case (stat.op)
                    OP_LOAD:  state_next = ST_LOAD;
                    OP_FILL:  state_next = ST_FILL_CLR;
                    OP_QUERY: state_next = ST_QRD;
                    default:  state_next = ST_FINISH;
                endcase
            ST_LOAD:  state_next = ST_FINISH;
            ST_QRD:   state_next = ST_FINISH;
            ST_FILL_CLR:
                if (stat.clr_last)
                    state_next = ST_SEED_RD;
            ST_SEED_RD: state_next = ST_SEED_CK;
            ST_SEED_CK:
                if (stat.seed_in && stat.open)
                begin
                    state_next = ST_L_RD;
                    seed_next  = 1'b1;
                end
                else
                    state_next = ST_FINISH;
            ST_L_RD:
                state_next = stat.lo_zero ? ST_R_RD : ST_L_CK;
            ST_L_CK:
                state_next = stat.open ? ST_L_RD : ST_R_RD;
            ST_R_RD:
                state_next = stat.hi_last ? ST_MARK : ST_R_CK;
            ST_R_CK:
                state_next = stat.open ? ST_R_RD : ST_MARK;
            ST_MARK:
                if (stat.mark_last)
                    state_next = ST_PUSH;
            ST_PUSH:
                state_next = seed_reg ? ST_POP : ST_S_RD;
            ST_POP:
                state_next = stat.sp_zero ? ST_FINISH : ST_POP_LD;
            ST_POP_LD:
            begin
                state_next = ST_ROW;
                phase_next = 1'b0;
            end
            ST_ROW:
                if (!phase_reg)
                begin
                    if (stat.has_below)
                        state_next = ST_S_RD;
                    else
                        phase_next = 1'b1;
                end
                else
                    state_next = stat.has_above ? ST_S_RD : ST_POP;
            ST_S_RD:
                if (stat.scan_end)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        state_next = ST_ROW;
                    end
                    else
                        state_next = ST_POP;
                end
                else
                    state_next = ST_S_CK;
            ST_S_CK:
                if (stat.open)
                begin
                    state_next = ST_L_RD;
                    seed_next  = 1'b0;
                end
                else
                    state_next = ST_S_RD;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = DP_NOP;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_BOOT_CLR: cmd = DP_CLEAR;
            ST_IDLE:     cmd = start ? DP_CAPTURE : DP_NOP;
            ST_LOAD:     cmd = DP_LOAD;
            ST_QRD:      cmd = DP_QRD;
            ST_FILL_CLR: cmd = DP_CLEAR;
            ST_SEED_RD:  cmd = DP_SEED_RD;
            ST_SEED_CK:  cmd = (stat.seed_in && stat.open) ? DP_SEED_SET : DP_NOP;
            ST_L_RD:     cmd = stat.lo_zero ? DP_NOP : DP_LRD;
            ST_L_CK:     cmd = stat.open ? DP_LDEC : DP_NOP;
            ST_R_RD:     cmd = stat.hi_last ? DP_MARK_INIT : DP_RRD;
            ST_R_CK:     cmd = stat.open ? DP_RINC : DP_MARK_INIT;
            ST_MARK:     cmd = DP_MARK;
            ST_PUSH:     cmd = DP_PUSH;
            ST_POP:      cmd = stat.sp_zero ? DP_NOP : DP_POP;
            ST_POP_LD:   cmd = DP_POP_LD;
            ST_ROW:
                if (!phase_reg)
                    cmd = stat.has_below ? DP_ROW_BELOW : DP_NOP;
                else
                    cmd = stat.has_above ? DP_ROW_ABOVE : DP_NOP;
            ST_S_RD:     cmd = stat.scan_end ? DP_NOP : DP_SRD;
            ST_S_CK:     cmd = stat.open ? DP_SCLAIM : DP_SSTEP;
            ST_FINISH:   cmd = DP_FINISH;
            default:     cmd = DP_NOP;
        endcase
    end

endmodule

// ----- hdl/sff_dp.sv -----
// Datapath of the flood fill: image store, mark map, span stack, span
// registers, counters and the result register. Depends on sff_pkg.
module sff_dp
    import sff_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         opcode,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [CHAN_W-1:0]  red,
    input  logic [CHAN_W-1:0]  green,
    input  logic [CHAN_W-1:0]  blue,
    input  logic               color_tolerance_we,
    input  logic [CHAN_W-1:0]  color_tolerance,
    input  dp_op_t             cmd,
    output dp_stat_t           stat,
    output logic               done,
    output logic               marked,
    output logic [COUNT_W-1:0] fill_count,
    output logic               stack_overflow
);

    localparam int XW  = $clog2(IMAGE_WIDTH);
    localparam int YW  = $clog2(IMAGE_HEIGHT);
    localparam int PIX = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW  = $clog2(PIX);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SEW = YW + 2 * XW;
    localparam int RGBW = 3 * CHAN_W;

    logic [RGBW-1:0] img_mem [PIX];
    logic            mark_mem [PIX];
    logic [SEW-1:0]  stk_mem [STACK_DEPTH];

    op_t                op_reg;
    logic [POS_W-1:0]   px_reg, py_reg;
    logic [RGBW-1:0]    rgb_reg;
    logic [CHAN_W-1:0]  tol_reg;
    logic               inside_reg;
    logic [XW-1:0]      lo_reg, hi_reg, mx_reg, slo_reg, shi_reg;
    logic [YW-1:0]      cy_reg, sy_reg, srow_reg;
    logic [XW:0]        x_reg;
    logic [SPW-1:0]     sp_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               ovf_reg;
    logic [AW-1:0]      clr_reg;
    logic [RGBW-1:0]    img_q;
    logic               mark_q;
    logic [SEW-1:0]     stk_q;
    logic               done_reg, marked_reg, sovf_reg;
    logic [COUNT_W-1:0] fcount_reg;

    logic [XW-1:0]  ax;
    logic [YW-1:0]  ay;
    logic [AW-1:0]  pix_addr;
    logic [SAW-1:0] stk_rd;
    logic           stk_full;
    logic           pix_open;

    always_comb
    begin
        ax = '0;
        ay = '0;
        case (cmd)
            DP_LOAD, DP_QRD, DP_SEED_RD:
            begin
                ax = XW'(px_reg);
                ay = YW'(py_reg);
            end
            DP_LRD:
            begin
                ax = lo_reg - XW'(1);
                ay = cy_reg;
            end
            DP_RRD:
            begin
                ax = hi_reg + XW'(1);
                ay = cy_reg;
            end
            DP_SRD:
            begin
                ax = x_reg[XW-1:0];
                ay = sy_reg;
            end
            DP_MARK:
            begin
                ax = mx_reg;
                ay = cy_reg;
            end
            default:
            begin
                ax = '0;
                ay = '0;
            end
        endcase
        if (cmd == DP_CLEAR)
            pix_addr = clr_reg;
        else
            pix_addr = AW'(32'(ay) * IMAGE_WIDTH + 32'(ax));
    end

    assign stk_rd   = SAW'(sp_reg - SPW'(1));
    assign stk_full = (sp_reg == SPW'(STACK_DEPTH));
    assign pix_open = !mark_q
                   && (img_q[3*CHAN_W-1:2*CHAN_W] <= tol_reg)
                   && (img_q[2*CHAN_W-1:CHAN_W] <= tol_reg)
                   && (img_q[CHAN_W-1:0] <= tol_reg);

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd == DP_LOAD && inside_reg)
            img_mem[pix_addr] <= rgb_reg;
        img_q <= img_mem[pix_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == DP_CLEAR)
            mark_mem[pix_addr] <= 1'b0;
        else if (cmd == DP_MARK)
            mark_mem[pix_addr] <= 1'b1;
        mark_q <= mark_mem[pix_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == DP_PUSH && !stk_full)
            stk_mem[sp_reg[SAW-1:0]] <= {cy_reg, lo_reg, hi_reg};
        stk_q <= stk_mem[stk_rd];
    end

    // Captured item, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd == DP_CAPTURE)
        begin
            op_reg     <= op_t'(opcode);
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            rgb_reg    <= {red, green, blue};
            inside_reg <= (32'(pos_x) < IMAGE_WIDTH) && (32'(pos_y) < IMAGE_HEIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOLERANCE_RST;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mx_reg     <= '0;
            slo_reg    <= '0;
            shi_reg    <= '0;
            cy_reg     <= '0;
            sy_reg     <= '0;
            srow_reg   <= '0;
            x_reg      <= '0;
            sp_reg     <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            marked_reg <= 1'b0;
            sovf_reg   <= 1'b0;
            fcount_reg <= '0;
        end
        else
        begin
            if (color_tolerance_we)
                tol_reg <= color_tolerance;
            done_reg <= 1'b0;
            case (cmd)
                DP_CLEAR:
                    clr_reg <= (clr_reg == AW'(PIX - 1)) ? '0 : clr_reg + AW'(1);
                DP_SEED_RD:
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                    sp_reg  <= '0;
                end
                DP_SEED_SET:
                begin
                    lo_reg <= XW'(px_reg);
                    hi_reg <= XW'(px_reg);
                    cy_reg <= YW'(py_reg);
                end
                DP_LDEC:      lo_reg <= lo_reg - XW'(1);
                DP_RINC:      hi_reg <= hi_reg + XW'(1);
                DP_MARK_INIT: mx_reg <= lo_reg;
                DP_MARK:
                begin
                    mx_reg <= mx_reg + XW'(1);
                    if (cnt_reg != COUNT_MAX)
                        cnt_reg <= cnt_reg + COUNT_W'(1);
                end
                DP_PUSH:
                begin
                    // resume the row scan just past the new span
                    x_reg <= {1'b0, hi_reg} + (XW + 1)'(1);
                    if (stk_full)
                        ovf_reg <= 1'b1;
                    else
                        sp_reg <= sp_reg + SPW'(1);
                end
                DP_POP:       sp_reg <= sp_reg - SPW'(1);
                DP_POP_LD:    {srow_reg, slo_reg, shi_reg} <= stk_q;
                DP_ROW_BELOW:
                begin
                    sy_reg <= srow_reg + YW'(1);
                    x_reg  <= {1'b0, slo_reg};
                end
                DP_ROW_ABOVE:
                begin
                    sy_reg <= srow_reg - YW'(1);
                    x_reg  <= {1'b0, slo_reg};
                end
                DP_SSTEP:     x_reg <= x_reg + (XW + 1)'(1);
                DP_SCLAIM:
                begin
                    lo_reg <= x_reg[XW-1:0];
                    hi_reg <= x_reg[XW-1:0];
                    cy_reg <= sy_reg;
                end
                DP_FINISH:
                begin
                    done_reg   <= 1'b1;
                    marked_reg <= (op_reg == OP_QUERY) && inside_reg && mark_q;
                    fcount_reg <= (op_reg == OP_FILL) ? cnt_reg : '0;
                    sovf_reg   <= (op_reg == OP_FILL) && ovf_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.seed_in   = inside_reg;
        stat.clr_last  = (clr_reg == AW'(PIX - 1));
        stat.open      = pix_open;
        stat.lo_zero   = (lo_reg == '0);
        stat.hi_last   = (hi_reg == XW'(IMAGE_WIDTH - 1));
        stat.mark_last = (mx_reg == hi_reg);
        stat.sp_zero   = (sp_reg == '0);
        stat.has_below = (srow_reg != YW'(IMAGE_HEIGHT - 1));
        stat.has_above = (srow_reg != '0);
        stat.scan_end  = (x_reg > {1'b0, shi_reg});
    end

    assign done           = done_reg;
    assign marked         = marked_reg;
    assign fill_count     = fcount_reg;
    assign stack_overflow = sovf_reg;

endmodule

// ----- hdl/scanline_flood_fill_threshold.sv -----
// Top level of the threshold flood fill: controller plus datapath.
// Depends on sff_pkg, sff_ctrl and sff_dp.
//
// An item is taken when start is high and busy is low; its single result
// appears on done for one cycle and cannot be held off. A load or a query
// passes through dispatch, its write or read state and finish. A fill
// first sweeps the mark map, one pixel per cycle, then walks the spans
// through single-port image and mark memories with registered reads: each
// pixel probed while growing a span or scanning a neighbor row is read,
// then checked; span pixels are marked one by one and each span is pushed
// and later popped. After reset the same mark-map sweep runs once with
// busy high; the tolerance register may be written at any idle time.
module scanline_flood_fill_threshold
    import sff_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [CHAN_W-1:0]  red,
    input  logic [CHAN_W-1:0]  green,
    input  logic [CHAN_W-1:0]  blue,
    input  logic               color_tolerance_we,
    input  logic [CHAN_W-1:0]  color_tolerance,
    output logic               done,
    output logic               marked,
    output logic [COUNT_W-1:0] fill_count,
    output logic               stack_overflow
);

    dp_op_t   cmd;
    dp_stat_t stat;

    sff_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sff_dp
    #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .STACK_DEPTH  (STACK_DEPTH)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .opcode             (opcode),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .color_tolerance_we (color_tolerance_we),
        .color_tolerance    (color_tolerance),
        .cmd                (cmd),
        .stat               (stat),
        .done               (done),
        .marked             (marked),
        .fill_count         (fill_count),
        .stack_overflow     (stack_overflow)
    );

endmodule

// ----- hdl/sff_checker.sv -----
// Port-level checks for the threshold flood fill, bound to the top level.
// Depends on sff_pkg.
module sff_checker
    import sff_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               marked,
    input logic [COUNT_W-1:0] fill_count,
    input logic               stack_overflow
);

    // an accepted transaction keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // overflow can only follow at least one marked span
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && stack_overflow |-> fill_count != '0)
        else $error("stack overflow reported with zero count");

    a_query_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && marked |-> fill_count == '0 && !stack_overflow)
        else $error("query result carries fill fields");

endmodule

bind scanline_flood_fill_threshold sff_checker u_sff_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .marked         (marked),
    .fill_count     (fill_count),
    .stack_overflow (stack_overflow)
);

// ----- tb/scanline_flood_fill_threshold_test.sv -----
// Self-checking testbench for the threshold flood fill block.
// Depends on sff_pkg and scanline_flood_fill_threshold; predicts every result itself.
`timescale 1ns / 100ps

module scanline_flood_fill_threshold_test;
    import sff_pkg::*;

    localparam int IMG_W       = DEF_IMAGE_WIDTH;
    localparam int IMG_H       = DEF_IMAGE_HEIGHT;
    localparam int NPIX        = IMG_W * IMG_H;
    localparam int SPAN_DEPTH  = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 32000000;
    localparam int RAND_ITEMS  = 950;

    typedef struct packed {
        logic               mark;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } fill_result_t;

    typedef struct {
        op_t               op;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        bit                typed;
        fill_result_t      res;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               color_tolerance_we;
    logic [CHAN_W-1:0]  color_tolerance;
    logic               done;
    logic               marked;
    logic [COUNT_W-1:0] fill_count;
    logic               stack_overflow;

    // shadow state of the block
    logic [CHAN_W-1:0] img_r [NPIX];
    logic [CHAN_W-1:0] img_g [NPIX];
    logic [CHAN_W-1:0] img_b [NPIX];
    bit                mark_bits [NPIX];
    int                span_row [SPAN_DEPTH];
    int                span_lo [SPAN_DEPTH];
    int                span_hi [SPAN_DEPTH];
    int                span_sp;
    logic [CHAN_W-1:0] tol_shadow;

    fill_result_t pending_results[$];
    int errors;
    int n_load, n_fill, n_query, n_none, n_ovf, n_checked, max_fill;
    int burst_left;

    scanline_flood_fill_threshold i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .opcode             (opcode),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .color_tolerance_we (color_tolerance_we),
        .color_tolerance    (color_tolerance),
        .done               (done),
        .marked             (marked),
        .fill_count         (fill_count),
        .stack_overflow     (stack_overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit px_open(int x, int y);
        int p;
        if (x < 0 || x >= IMG_W || y < 0 || y >= IMG_H)
            return 0;
        p = y * IMG_W + x;
        if (mark_bits[p])
            return 0;
        return img_r[p] <= tol_shadow && img_g[p] <= tol_shadow && img_b[p] <= tol_shadow;
    endfunction

    task automatic grow_span(input int x, input int y, inout int cnt, inout bit ovf,
                             output int right);
        int lo;
        int hi;
        lo = x;
        hi = x;
        while (lo > 0 && px_open(lo - 1, y))
            lo--;
        while (hi + 1 < IMG_W && px_open(hi + 1, y))
            hi++;
        for (int i = lo; i <= hi; i++)
        begin
            mark_bits[y * IMG_W + i] = 1;
            if (cnt < COUNT_MAX)
                cnt++;
        end
        // a span that finds the stack full is still counted, just not explored
        if (span_sp < SPAN_DEPTH)
        begin
            span_row[span_sp] = y;
            span_lo[span_sp]  = lo;
            span_hi[span_sp]  = hi;
            span_sp++;
        end
        else
            ovf = 1;
        right = hi;
    endtask

    task automatic scan_neighbor(input int lo, input int hi, input int y, inout int cnt,
                                 inout bit ovf);
        int x;
        int right;
        x = lo;
        while (x <= hi)
        begin
            if (px_open(x, y))
            begin
                grow_span(x, y, cnt, ovf, right);
                x = right + 1;
            end
            else
                x++;
        end
    endtask

    task automatic flood_fill(input int sx, input int sy, output int cnt, output bit ovf);
        int right;
        int row, lo, hi;
        foreach (mark_bits[i])
            mark_bits[i] = 0;
        span_sp = 0;
        cnt = 0;
        ovf = 0;
        if (px_open(sx, sy))
        begin
            grow_span(sx, sy, cnt, ovf, right);
            while (span_sp > 0)
            begin
                span_sp--;
                row = span_row[span_sp];
                lo  = span_lo[span_sp];
                hi  = span_hi[span_sp];
                if (row + 1 < IMG_H)
                    scan_neighbor(lo, hi, row + 1, cnt, ovf);
                if (row > 0)
                    scan_neighbor(lo, hi, row - 1, cnt, ovf);
            end
        end
    endtask

    task automatic predict_item(stim_row_t it, output fill_result_t res);
        int p;
        int cnt;
        bit ovf;
        p = it.y * IMG_W + it.x;
        res = '{1'b0, '0, 1'b0};
        case (it.op)
            OP_LOAD:
            begin
                img_r[p] = it.r;
                img_g[p] = it.g;
                img_b[p] = it.b;
                n_load++;
            end
            OP_FILL:
            begin
                flood_fill(it.x, it.y, cnt, ovf);
                res.count = cnt[COUNT_W-1:0];
                res.ovf   = ovf;
                if (cnt > max_fill)
                    max_fill = cnt;
                if (ovf)
                    n_ovf++;
                n_fill++;
            end
            OP_QUERY:
            begin
                res.mark = mark_bits[p];
                n_query++;
            end
            default:
                n_none++;
        endcase
    endtask

    // hold start through the transaction, with random gaps between bursts
    task automatic issue(stim_row_t it);
        fill_result_t res;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start  <= 1'b1;
        opcode <= it.op;
        pos_x  <= it.x;
        pos_y  <= it.y;
        red    <= it.r;
        green  <= it.g;
        blue   <= it.b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_item(it, res);
        if (it.typed && res != it.res)
        begin
            $display("[%0t] table row disagrees with prediction", $realtime);
            errors++;
        end
        pending_results.push_back(it.typed ? it.res : res);
    endtask

    task automatic settle;
        start <= 1'b0;
        burst_left = 0;
        while (pending_results.size() > 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic set_tolerance(logic [CHAN_W-1:0] value);
        settle();
        color_tolerance_we <= 1'b1;
        color_tolerance    <= value;
        @(posedge clk);
        color_tolerance_we <= 1'b0;
        tol_shadow = value;
    endtask

    // mostly dark pixels so fills spread, the rest anywhere in range
    function automatic stim_row_t random_load(int x, int y);
        stim_row_t it;
        int hi_ch;
        hi_ch = ($urandom_range(0, 9) < 6) ? 60 : 255;
        it = '{OP_LOAD, x[POS_W-1:0], y[POS_W-1:0], CHAN_W'($urandom_range(0, hi_ch)),
               CHAN_W'($urandom_range(0, hi_ch)), CHAN_W'($urandom_range(0, hi_ch)), 0,
               '{1'b0, '0, 1'b0}};
        return it;
    endfunction

    function automatic stim_row_t random_item();
        stim_row_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it = random_load($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1));
        if (pick >= 50 && pick < 88)
            it.op = OP_QUERY;
        else if (pick >= 88 && pick < 94)
            it.op = OP_FILL;
        else if (pick >= 94)
            it.op = OP_NONE;
        if (it.op != OP_LOAD)
        begin
            it.r = CHAN_W'($urandom_range(0, 255));
            it.g = CHAN_W'($urandom_range(0, 255));
            it.b = CHAN_W'($urandom_range(0, 255));
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        fill_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result with nothing pending", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (marked !== want.mark)
                    report("marked", marked, want.mark);
                if (fill_count !== want.count)
                    report("fill_count", fill_count, want.count);
                if (stack_overflow !== want.ovf)
                    report("stack_overflow", stack_overflow, want.ovf);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout with %0d results pending", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t dir_rows[$];
        logic [CHAN_W-1:0] tol_steps[4];

        errors = 0;
        n_load = 0;
        n_fill = 0;
        n_query = 0;
        n_none = 0;
        n_ovf = 0;
        n_checked = 0;
        max_fill = 0;
        burst_left = 0;
        span_sp = 0;
        tol_shadow = TOLERANCE_RST;
        foreach (mark_bits[i])
            mark_bits[i] = 0;
        rst_n              = 1'b0;
        start              = 1'b0;
        opcode             = OP_NONE;
        pos_x              = '0;
        pos_y              = '0;
        red                = '0;
        green              = '0;
        blue               = '0;
        color_tolerance_we = 1'b0;
        color_tolerance    = TOLERANCE_RST;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_tolerance(TOLERANCE_RST);

        // reads before any fill see the cleared mark map
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 63, 63, 8'hff, 8'hff, 8'hff, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_NONE, 63, 63, 8'hff, 8'hff, 8'hff, 1, '{1'b0, 13'd0, 1'b0}});
        foreach (dir_rows[i])
            issue(dir_rows[i]);
        dir_rows.delete();

        // write every pixel before any fill can read one
        for (int p = 0; p < NPIX; p++)
            issue(random_load(p % IMG_W, p / IMG_W));

        dir_rows.push_back('{OP_LOAD, 0, 0, 8'hff, 8'hff, 8'hff, 1, '{1'b0, 13'd0, 1'b0}});
        // seed that does not qualify: nothing marked
        dir_rows.push_back('{OP_FILL, 0, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 63, 63, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 0, 63, 60, 60, 60, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 63, 0, 61, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 1, 0, 0, 61, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 0, 1, 0, 0, 61, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_FILL, 63, 63, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 63, 63, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 0, 63, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 63, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 0, 0, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_FILL, 0, 0, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 0, 0, 0, 0, 0, 1, '{1'b1, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_FILL, 32, 31, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_QUERY, 31, 32, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_NONE, 0, 0, 0, 0, 0, 1, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 42, 21, 8'haa, 8'h55, 8'hff, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_LOAD, 21, 42, 8'h55, 8'haa, 8'h00, 0, '{1'b0, 13'd0, 1'b0}});
        dir_rows.push_back('{OP_FILL, 21, 42, 0, 0, 0, 0, '{1'b0, 13'd0, 1'b0}});
        foreach (dir_rows[i])
            issue(dir_rows[i]);

        // whole image, only all-zero pixels, something in between, then back to reset value
        tol_steps = '{8'd255, 8'd0, 8'($urandom_range(1, 254)), TOLERANCE_RST};
        foreach (tol_steps[s])
        begin
            set_tolerance(tol_steps[s]);
            for (int n = 0; n < RAND_ITEMS / 4; n++)
                issue(random_item());
        end

        settle();
        repeat (20)
            @(posedge clk);
        $display("covered %0d loads, %0d fills (largest %0d, %0d overflowed), %0d queries,",
                 n_load, n_fill, max_fill, n_ovf, n_query);
        $display("%0d no-ops; %0d results checked across five tolerance settings",
                 n_none, n_checked);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sff_pkg.sv
hdl/sff_ctrl.sv
hdl/sff_dp.sv
hdl/scanline_flood_fill_threshold.sv
hdl/sff_checker.sv
tb/scanline_flood_fill_threshold_test.sv
